[rtl/core/dle_escaped_frame_receiver_defines.svh]
// ----------------------------------------------------------------------------
// dle_escaped_frame_receiver_defines.svh
// Assertion macros used by the frame receiver top level.
// ----------------------------------------------------------------------------
`ifndef DLE_ESCAPED_FRAME_RECEIVER_DEFINES_SVH
`define DLE_ESCAPED_FRAME_RECEIVER_DEFINES_SVH

// Condition must never hold outside reset.
`define DLERX_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("dlerx: forbidden condition seen");

// Antecedent in a cycle requires consequent in the same cycle.
`define DLERX_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dlerx: implication violated");

`endif

[rtl/core/dlerx_pkg.sv]
// ----------------------------------------------------------------------------
// dlerx_pkg
// Shared constants and types of the escaped frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dlerx_pkg;

  // Frame capacity default and the fixed width of a frame length
  localparam int MAX_FRAME_DEF = 64;
  localparam int CNT_W         = 7;
  localparam int MIN_FRAME     = 2;

  // Byte codes and their reset values
  localparam int         CODE_W    = 8;
  localparam logic [7:0] START_RST = 8'd2;
  localparam logic [7:0] END_RST   = 8'd3;
  localparam logic [7:0] ESC_RST   = 8'd16;

  // Configuration register indexes
  localparam int         CFG_IDX_W = 2;
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_ESC   = 2'd2;

  // Result queue in front of the output ports
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;

  // Description of one finished frame waiting in a buffer bank
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } desc_t;

  // One slot of the frame queue: push request or current head
  typedef struct packed {
    logic  valid;
    logic  bank;
    desc_t desc;
  } qslot_t;

  // One result item
  typedef struct packed {
    logic [CODE_W-1:0] data;
    logic              last;
    logic              ovf;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/dle_escaped_frame_receiver.sv]
// Output: the first byte of a frame reaches the result ports only after its end
//   code is transferred; later bytes follow one per cycle while the result queue has room.
// Throughput: one received byte per cycle; intake stalls only while both
//   frame buffer banks hold finished frames waiting to drain.
// Reset: synchronous, clears framing, queue and drain state and restores the
//   default codes; buffer contents are not cleared.
// ----------------------------------------------------------------------------
// dle_escaped_frame_receiver
// Start/end/escape byte-stuffed frame receiver with a decoupled drain path.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dle_escaped_frame_receiver_defines.svh"

module dle_escaped_frame_receiver #(
  parameter int MAX_FRAME = dlerx_pkg::MAX_FRAME_DEF,
  localparam int AW = $clog2(MAX_FRAME)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dlerx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlerx_pkg::CODE_W-1:0]    cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [dlerx_pkg::CODE_W-1:0]    rx_byte,
  output logic                           empty,
  input  logic                           pop,
  output logic [dlerx_pkg::CODE_W-1:0]    payload_byte,
  output logic                           frame_last,
  output logic                           frame_overflow
);

  logic                         wr_en;
  logic                         wr_bank;
  logic [AW-1:0]                wr_addr;
  logic [dlerx_pkg::CODE_W-1:0] wr_data;
  dlerx_pkg::qslot_t            qpush;
  dlerx_pkg::qslot_t            head;
  logic [1:0]                   busy;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [dlerx_pkg::CODE_W-1:0] rd_data;
  logic                         qpop;

  // Classifier
  dlerx_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .rx_byte   (rx_byte),
    .busy      (busy),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .qpush     (qpush)
  );

  // Frame queue
  dlerx_fbuf #(.MAX_FRAME(MAX_FRAME)) u_fbuf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_bank (wr_bank),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .qpush   (qpush),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .qpop    (qpop),
    .rd_data (rd_data),
    .busy    (busy),
    .head    (head)
  );

  // Drain sequencer
  dlerx_back #(.MAX_FRAME(MAX_FRAME)) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .rd_data        (rd_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .qpop           (qpop),
    .empty          (empty),
    .pop            (pop),
    .payload_byte   (payload_byte),
    .frame_last     (frame_last),
    .frame_overflow (frame_overflow)
  );

  // A stalled intake means both banks hold undrained frames
  `DLERX_ASSERT_IMPLY(a_full_both_busy, full, busy == 2'b11)
  // A finished frame never lands in a bank still owned by the drain side
  `DLERX_ASSERT_NEVER(a_push_busy_bank, qpush.valid && busy[qpush.bank])
  // The drain side releases only a bank it owns
  `DLERX_ASSERT_IMPLY(a_pop_owned, qpop, head.valid)

endmodule

`default_nettype wire

[rtl/core/dlerx_front.sv]
// ----------------------------------------------------------------------------
// dlerx_front
// Byte classifier: tracks framing and escape state, writes payload bytes
// into the current buffer bank and pushes a descriptor at the end of a frame of MIN_FRAME or more bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module dlerx_front #(
  parameter int MAX_FRAME = dlerx_pkg::MAX_FRAME_DEF,
  localparam int AW = $clog2(MAX_FRAME),
  localparam int CW = $clog2(MAX_FRAME + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dlerx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlerx_pkg::CODE_W-1:0]    cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [dlerx_pkg::CODE_W-1:0]    rx_byte,
  input  logic [1:0]                     busy,
  output logic                           wr_en,
  output logic                           wr_bank,
  output logic [AW-1:0]                  wr_addr,
  output logic [dlerx_pkg::CODE_W-1:0]    wr_data,
  output dlerx_pkg::qslot_t              qpush
);

  logic [dlerx_pkg::CODE_W-1:0] start_code;
  logic [dlerx_pkg::CODE_W-1:0] end_code;
  logic [dlerx_pkg::CODE_W-1:0] escape_code;
  logic                         in_frame;
  logic                         esc_pend;
  logic                         ovf;
  logic                         wbank;
  logic [CW-1:0]                count;

  logic accept;
  logic is_start;
  logic is_end;
  logic is_esc;
  logic is_data;
  logic store_ok;

  // Stall intake while the bank being filled still waits to be drained
  assign full   = busy[wbank];
  assign accept = push && !full;

  // Classify the byte; start is tested outside a frame, end inside one
  assign is_start = !in_frame && (rx_byte == start_code) && !esc_pend;
  assign is_end   = in_frame && (rx_byte == end_code) && !esc_pend;
  assign is_esc   = (rx_byte == escape_code) && !esc_pend;
  assign is_data  = !is_start && !is_end && !is_esc;
  assign store_ok = count < CW'(MAX_FRAME);

  // Payload write into the current bank
  assign wr_en   = accept && is_data && in_frame && store_ok;
  assign wr_bank = wbank;
  assign wr_addr = count[AW-1:0];
  assign wr_data = rx_byte;

  // Hand a finished frame of useful length to the back end
  assign qpush.valid      = accept && is_end && (count >= CW'(dlerx_pkg::MIN_FRAME));
  assign qpush.bank       = wbank;
  assign qpush.desc.count = dlerx_pkg::CNT_W'(count);
  assign qpush.desc.ovf   = ovf;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_code  <= dlerx_pkg::START_RST;
      end_code    <= dlerx_pkg::END_RST;
      escape_code <= dlerx_pkg::ESC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dlerx_pkg::REG_START: start_code  <= cfg_data;
        dlerx_pkg::REG_END:   end_code    <= cfg_data;
        dlerx_pkg::REG_ESC:   escape_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Framing state: advance on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      esc_pend <= 1'b0;
      ovf      <= 1'b0;
      count    <= '0;
      wbank    <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        in_frame <= 1'b1;
        count    <= '0;
        ovf      <= 1'b0;
      end else if (is_end) begin
        in_frame <= 1'b0;
        count    <= '0;
        ovf      <= 1'b0;
        if (qpush.valid) begin
          wbank <= !wbank;
        end
      end else begin
        esc_pend <= is_esc;
        if (!is_esc && in_frame) begin
          if (store_ok) begin
            count <= count + CW'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/dlerx_fbuf.sv]
// ----------------------------------------------------------------------------
// dlerx_fbuf
// Two-bank frame buffer with one descriptor per bank; the banks form a
// two-entry frame queue between the classifier and the drain sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dlerx_fbuf #(
  parameter int MAX_FRAME = dlerx_pkg::MAX_FRAME_DEF,
  localparam int AW = $clog2(MAX_FRAME)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic                        wr_bank,
  input  logic [AW-1:0]               wr_addr,
  input  logic [dlerx_pkg::CODE_W-1:0] wr_data,
  input  dlerx_pkg::qslot_t           qpush,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        qpop,
  output logic [dlerx_pkg::CODE_W-1:0] rd_data,
  output logic [1:0]                  busy,
  output dlerx_pkg::qslot_t           head
);

  logic [dlerx_pkg::CODE_W-1:0] mem [2 << AW];
  dlerx_pkg::desc_t             desc_q [2];
  logic                         rbank;

  // Oldest waiting frame
  assign head.valid = busy[rbank];
  assign head.bank  = rbank;
  assign head.desc  = desc_q[rbank];

  // Payload write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_bank, wr_addr}] <= wr_data;
    end
  end

  // Registered read from the head bank
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[{rbank, rd_addr}];
    end
  end

  // Descriptor slots
  always_ff @(posedge clk) begin
    if (qpush.valid) begin
      desc_q[qpush.bank] <= qpush.desc;
    end
  end

  // Bank ownership: set on push, release on pop and advance the head
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 2'b00;
      rbank <= 1'b0;
    end else begin
      if (qpush.valid) begin
        busy[qpush.bank] <= 1'b1;
      end
      if (qpop) begin
        busy[rbank] <= 1'b0;
        rbank       <= !rbank;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/dlerx_back.sv]
// ----------------------------------------------------------------------------
// dlerx_back
// Drain sequencer: reads a finished frame out of its bank one byte per
// cycle while the result queue has room and queues the results for the output ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dlerx_back #(
  parameter int MAX_FRAME = dlerx_pkg::MAX_FRAME_DEF,
  localparam int AW = $clog2(MAX_FRAME)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dlerx_pkg::qslot_t           head,
  input  logic [dlerx_pkg::CODE_W-1:0] rd_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  output logic                        qpop,
  output logic                        empty,
  input  logic                        pop,
  output logic [dlerx_pkg::CODE_W-1:0] payload_byte,
  output logic                        frame_last,
  output logic                        frame_overflow
);

  localparam int PW = dlerx_pkg::OQ_PTR_W;

  logic                        active;
  logic [AW-1:0]               idx;
  logic [dlerx_pkg::CNT_W-1:0] cnt;
  logic                        ovf;
  logic                        rvalid;
  logic                        rlast;
  logic                        rovf;

  dlerx_pkg::out_item_t oq [dlerx_pkg::OQ_DEPTH];
  logic [PW-1:0]        wptr;
  logic [PW-1:0]        rptr;
  logic [PW:0]          ocount;

  logic                 room;
  logic                 last_issue;
  logic                 oq_re;
  logic [PW+1:0]        pending;

  // Issue a read only when the result queue can take it
  assign pending    = {1'b0, ocount} + (PW + 2)'(rvalid);
  assign room       = pending < (PW + 2)'(dlerx_pkg::OQ_DEPTH);
  assign rd_en      = active && room;
  assign rd_addr    = idx;
  assign last_issue = (dlerx_pkg::CNT_W'(idx) + dlerx_pkg::CNT_W'(1)) == cnt;
  assign qpop       = rd_en && last_issue;

  // Result queue head on the ports
  assign empty          = (ocount == '0);
  assign oq_re          = pop && !empty;
  assign payload_byte   = oq[rptr].data;
  assign frame_last     = oq[rptr].last;
  assign frame_overflow = oq[rptr].ovf;

  // Drain sequencer: take the head frame, walk its bytes, release the bank
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= rd_en;
      if (!active) begin
        if (head.valid) begin
          active <= 1'b1;
        end
      end else if (qpop) begin
        active <= 1'b0;
      end
    end
  end

  // Sequencer payload: frame length, flag and byte index
  always_ff @(posedge clk) begin
    if (!active) begin
      idx <= '0;
      cnt <= head.desc.count;
      ovf <= head.desc.ovf;
    end else if (rd_en) begin
      idx <= idx + AW'(1);
    end
    if (rd_en) begin
      rlast <= last_issue;
      rovf  <= ovf;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (rvalid) begin
      oq[wptr] <= '{data: rd_data, last: rlast, ovf: rovf};
    end
  end

  // Result queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      ocount <= '0;
    end else begin
      if (rvalid) begin
        wptr <= wptr + PW'(1);
      end
      if (oq_re) begin
        rptr <= rptr + PW'(1);
      end
      ocount <= ocount + (PW + 1)'(rvalid) - (PW + 1)'(oq_re);
    end
  end

endmodule

`default_nettype wire
